>>> rtl/core/bps_pkg.sv
// Shared types and constants for the byte pattern search block.
`default_nettype none
package bps_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int PAT_IDX_W     = $clog2(MAX_PATTERN);
   localparam int LEN_W         = 5;
   localparam int OFFSET_BITS   = 40;
   localparam int POS_INC_W     = OFFSET_BITS + 1;
   localparam int PATTERN_BYTES = 16;
   localparam int PATTERN_W     = 8 * PATTERN_BYTES;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_START_OFFSET = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_BACKWARD     = CSR_IDX_W'(4);

   typedef struct packed {
      logic [PATTERN_W-1:0]   pattern;
      logic [LEN_W-1:0]       pattern_length;
      logic [OFFSET_BITS:0]   start_offset;
      logic                   search_backward;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } item_type;

   typedef struct packed {
      logic                   found;
      logic [OFFSET_BITS-1:0] match_offset;
      logic                   status;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/core/bps_intf.sv
// Channel interfaces: input byte beats, result beats and register writes.
`default_nettype none
interface bps_req_if;
   import bps_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface bps_rsp_if;
   import bps_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   found;
   logic [OFFSET_BITS-1:0] match_offset;
   logic                   status;
   modport source (output valid, output found, output match_offset, output status,
                   input ready);
   modport sink   (input valid, input found, input match_offset, input status,
                   output ready);
endinterface

interface bps_csr_if;
   import bps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] write_data;
   modport source (output valid, output index, output write_data, input ready);
   modport sink   (input valid, input index, input write_data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bps_csr_regs.sv
// Configuration registers of the byte pattern search.
`default_nettype none
module bps_csr_regs (
   input  logic              clock,
   input  logic              reset,
   bps_csr_if.sink           csr_bus,
   output bps_pkg::cfg_type  cfg
);
   import bps_pkg::*;

   logic [CSR_DATA_W-1:0]  pat_low_ff;
   logic [CSR_DATA_W-1:0]  pat_high_ff;
   logic [LEN_W-1:0]       pat_len_ff;
   logic [OFFSET_BITS:0]   start_ff;
   logic                   backward_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= LEN_W'(1);
         start_ff    <= '1;
         backward_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_bus.write_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_bus.write_data;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_bus.write_data[LEN_W-1:0];
            CSR_START_OFFSET: start_ff    <= csr_bus.write_data[OFFSET_BITS:0];
            CSR_BACKWARD:     backward_ff <= csr_bus.write_data[0];
            default: ;
         endcase
      end
   end

   assign cfg.pattern         = {pat_high_ff, pat_low_ff};
   assign cfg.pattern_length  = pat_len_ff;
   assign cfg.start_offset    = start_ff;
   assign cfg.search_backward = backward_ff;

endmodule
`default_nettype wire

>>> rtl/core/bps_in_stage.sv
// Input register for byte beats.
`default_nettype none
module bps_in_stage (
   input  logic               clock,
   input  logic               reset,
   bps_req_if.sink            req_bus,
   input  logic               advance,
   output logic               item_vld,
   output bps_pkg::item_type  item
);
   import bps_pkg::*;

   logic     vld_ff;
   item_type item_ff;
   logic     take;

   assign req_bus.ready = !vld_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (take) begin
         vld_ff <= 1'b1;
      end else if (advance) begin
         vld_ff <= 1'b0;
      end
      if (take) begin
         item_ff.data_byte <= req_bus.data_byte;
         item_ff.last      <= req_bus.last;
      end
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule
`default_nettype wire

>>> rtl/core/bps_match_core.sv
// Byte window, parallel pattern compare, match tracking and result register.
`default_nettype none
module bps_match_core (
   input  logic               clock,
   input  logic               reset,
   input  bps_pkg::cfg_type   cfg,
   input  logic               item_vld,
   input  bps_pkg::item_type  item,
   output logic               advance,
   bps_rsp_if.source          rsp_bus
);
   import bps_pkg::*;

   logic [7:0]             win_ff [MAX_PATTERN];
   logic [7:0]             win_in [MAX_PATTERN];
   logic [7:0]             pat_bytes [MAX_PATTERN];
   logic [OFFSET_BITS-1:0] pos_ff;
   logic                   seen_ff;
   logic [OFFSET_BITS-1:0] best_ff;
   logic                   seen_in;
   logic [OFFSET_BITS-1:0] best_in;
   logic                   rsp_vld_ff;
   result_type             rsp_data_ff;
   result_type             result_in;

   logic [LEN_W-1:0]       plen;
   logic [LEN_W-1:0]       idx;
   logic                   hit;
   logic [POS_INC_W-1:0]   pos_inc;
   logic [POS_INC_W-1:0]   diff;
   logic [OFFSET_BITS-1:0] cand;
   logic                   check;
   logic                   allowed;
   logic                   take;
   logic                   out_free;

   assign out_free = !rsp_vld_ff || rsp_bus.ready;
   assign advance  = item_vld && (!item.last || out_free);

   always_comb begin
      plen = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                       : cfg.pattern_length;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         pat_bytes[k] = (k < PATTERN_BYTES) ? cfg.pattern[8*k +: 8] : 8'h00;
      end
      win_in[0] = item.data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         win_in[i] = win_ff[i-1];
      end
      // window entry j lines up with pattern byte plen-1-j
      hit = 1'b1;
      idx = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         idx = plen - LEN_W'(j) - LEN_W'(1);
         if (LEN_W'(j) < plen && win_in[j] != pat_bytes[idx[PAT_IDX_W-1:0]]) begin
            hit = 1'b0;
         end
      end
      pos_inc = {1'b0, pos_ff} + POS_INC_W'(1);
      check   = (plen != '0) && (pos_inc >= POS_INC_W'(plen));
      diff    = pos_inc - POS_INC_W'(plen);
      cand    = diff[OFFSET_BITS-1:0];
      if (cfg.search_backward) begin
         allowed = cfg.start_offset[OFFSET_BITS] ||
                   (cand < cfg.start_offset[OFFSET_BITS-1:0]);
      end else begin
         allowed = !seen_ff && (cfg.start_offset[OFFSET_BITS] ||
                   (cand >= cfg.start_offset[OFFSET_BITS-1:0]));
      end
      take    = check && hit && allowed;
      seen_in = seen_ff || take;
      best_in = take ? cand : best_ff;
      result_in.found        = (plen != '0) && seen_in;
      result_in.match_offset = ((plen != '0) && seen_in) ? best_in : '0;
      result_in.status       = (plen == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ff[i] <= 8'h00;
         end
         pos_ff     <= '0;
         seen_ff    <= 1'b0;
         best_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (advance) begin
            if (item.last) begin
               for (int i = 0; i < MAX_PATTERN; i++) begin
                  win_ff[i] <= 8'h00;
               end
               pos_ff  <= '0;
               seen_ff <= 1'b0;
               best_ff <= '0;
            end else begin
               for (int i = 0; i < MAX_PATTERN; i++) begin
                  win_ff[i] <= win_in[i];
               end
               pos_ff  <= pos_inc[OFFSET_BITS-1:0];
               seen_ff <= seen_in;
               best_ff <= best_in;
            end
         end
         if (advance && item.last) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      if (advance && item.last) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.found        = rsp_data_ff.found;
   assign rsp_bus.match_offset = rsp_data_ff.match_offset;
   assign rsp_bus.status       = rsp_data_ff.status;

`ifndef SYNTH
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && item.last |=> pos_ff == '0 && !seen_ff && best_ff == '0)
      else $error("file state not cleared after last beat");
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      advance && !item.last |=> pos_ff == $past(pos_ff) + OFFSET_BITS'(1))
      else $error("byte position did not step");
   a_err_no_found: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_data_ff.status && rsp_data_ff.found))
      else $error("found set with empty pattern");
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_data_ff.found |-> rsp_data_ff.match_offset == '0)
      else $error("offset nonzero without a match");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_bus.ready |-> !(advance && item.last))
      else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

>>> rtl/core/byte_pattern_search_top.sv
// Top level: one byte per cycle, window compare, one result per file.
// A last byte beat passes the input register, then the result register, which drives result valid.
// Throughput: one byte beat per cycle; a held result holds back a last beat and those behind it.
// The compare of the 16-byte window and the offset checks sit in one stage.
// Synchronous reset clears the window, position and match state, the result
// valid, and loads the registers with length 1 and start offset -1.
`default_nettype none
module byte_pattern_search_top (
   input  logic        clock,
   input  logic        reset,
   bps_req_if.sink     req_bus,
   bps_rsp_if.source   rsp_bus,
   bps_csr_if.sink     csr_bus
);
   import bps_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     item_vld;
   logic     advance;

   bps_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bps_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .advance  (advance),
      .item_vld (item_vld),
      .item     (item)
   );

   bps_match_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .item_vld (item_vld),
      .item     (item),
      .advance  (advance),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire
